[hdl/qvm_pkg.sv]
`default_nettype none
package qvm_pkg;

  localparam int WindowBits = 16;
  localparam int TotalBits  = 32;
  localparam int IntervalW  = 16;
  localparam int ScaleW     = 24;
  localparam int RateW      = 40;
  localparam int DistW      = 56;
  localparam int InDataW    = 8;
  localparam int OutDataW   = 192;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 24;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic signed [WindowBits-1:0] WindowMax = (WindowBits)'((1 << (WindowBits - 1)) - 1);
  localparam logic [IntervalW-1:0] ElapsedMax   = '1;
  localparam logic [IntervalW-1:0] IntervalRst  = 16'd250;
  localparam logic [ScaleW-1:0]    RpmScaleRst  = 24'd1981562;
  localparam logic [ScaleW-1:0]    SpeedScaleRst = 24'd9901;
  localparam logic [ScaleW-1:0]    DistScaleRst = 24'd2475;

  typedef enum logic [CfgIndexW-1:0] {
    REG_INTERVAL_MS    = 2'd0,
    REG_RPM_SCALE      = 2'd1,
    REG_SPEED_SCALE    = 2'd2,
    REG_DISTANCE_SCALE = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_RPM,
    BACK_SPEED,
    BACK_DIST,
    BACK_HOLD
  } back_state_t;

  // One finished window as handed from the front to the back.
  typedef struct packed {
    logic signed [WindowBits-1:0] window;
    logic signed [TotalBits-1:0]  total;
    logic                         reverse;
  } snap_t;

  typedef struct packed {
    logic [ScaleW-1:0] rpm;
    logic [ScaleW-1:0] speed;
    logic [ScaleW-1:0] distance;
  } scales_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

[hdl/quadrature_velocity_meter.sv]
`default_nettype none
// Quadrature encoder velocity meter with x4 decoding. One encoder sample is
// taken on every clock cycle (s_tready stays high unless two finished
// windows are already waiting), so the block sustains one request per cycle.
// Every sample updates direction, a saturating window count and a wrapping
// total count; when the millisecond ticks reach interval_ms, the window is
// snapshotted into a two-entry queue and cleared. The back end takes each
// snapshot through one shared 32 x 24 multiplier three times (rpm, speed,
// distance), so a result request appears on the master side after the queue
// and the IDLE, RPM, SPEED and DIST states and is held until it is taken.
// Results have no saturation path because the fixed 16- and 32-bit counts
// times a 24-bit scale always fit the 40- and 56-bit result fields. Configuration is
// written through cfg_we, cfg_index and cfg_data and takes effect
// immediately; it should be changed only while no window result is pending.
module quadrature_velocity_meter (
  input  wire                                 clk,
  input  wire                                 rst,
  // Input sample: [0] pin_a, [1] pin_b, [2] tick, upper bits zero.
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [qvm_pkg::InDataW-1:0]         s_tdata,
  // Window result: [39:0] rpm_fixed, [79:40] speed_fixed,
  // [135:80] distance_fixed, [151:136] window_pulses,
  // [183:152] total_pulses, [184] reverse, upper bits zero.
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [qvm_pkg::OutDataW-1:0]        m_tdata,
  input  wire                                 cfg_we,
  input  wire  [qvm_pkg::CfgIndexW-1:0]       cfg_index,
  input  wire  [qvm_pkg::CfgDataW-1:0]        cfg_data
);

  logic [qvm_pkg::IntervalW-1:0] interval_ms;
  qvm_pkg::scales_t              scales;
  qvm_pkg::queue_ctl_t           q_ctl;
  qvm_pkg::queue_stat_t          q_stat;
  qvm_pkg::snap_t                q_wr;
  qvm_pkg::snap_t                q_rd;
  logic                          q_push;
  logic                          q_pop;
  logic                          accept;

  logic signed [qvm_pkg::RateW-1:0]      rpm_fixed;
  logic signed [qvm_pkg::RateW-1:0]      speed_fixed;
  logic signed [qvm_pkg::DistW-1:0]      distance_fixed;
  logic signed [qvm_pkg::WindowBits-1:0] window_pulses;
  logic signed [qvm_pkg::TotalBits-1:0]  total_pulses;
  logic                                  reverse;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms     <= qvm_pkg::IntervalRst;
      scales.rpm      <= qvm_pkg::RpmScaleRst;
      scales.speed    <= qvm_pkg::SpeedScaleRst;
      scales.distance <= qvm_pkg::DistScaleRst;
    end else if (cfg_we) begin
      case (qvm_pkg::reg_index_t'(cfg_index))
        qvm_pkg::REG_INTERVAL_MS:    interval_ms     <= cfg_data[qvm_pkg::IntervalW-1:0];
        qvm_pkg::REG_RPM_SCALE:      scales.rpm      <= cfg_data[qvm_pkg::ScaleW-1:0];
        qvm_pkg::REG_SPEED_SCALE:    scales.speed    <= cfg_data[qvm_pkg::ScaleW-1:0];
        qvm_pkg::REG_DISTANCE_SCALE: scales.distance <= cfg_data[qvm_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // A sample is held off only while the queue is full, since it might close a window.
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign q_ctl    = '{push: q_push, pop: q_pop};

  qvm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pin_a       (s_tdata[0]),
    .pin_b       (s_tdata[1]),
    .tick        (s_tdata[2]),
    .interval_ms (interval_ms),
    .push        (q_push),
    .snap        (q_wr)
  );

  qvm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (q_ctl),
    .wr_data (q_wr),
    .stat    (q_stat),
    .rd_data (q_rd)
  );

  qvm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .q_data         (q_rd),
    .scales         (scales),
    .pop            (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .rpm_fixed      (rpm_fixed),
    .speed_fixed    (speed_fixed),
    .distance_fixed (distance_fixed),
    .window_pulses  (window_pulses),
    .total_pulses   (total_pulses),
    .reverse        (reverse)
  );

  assign m_tdata = {7'd0, reverse, total_pulses, window_pulses, distance_fixed,
                    speed_fixed, rpm_fixed};

endmodule
`default_nettype wire

[hdl/qvm_queue.sv]
`default_nettype none
module qvm_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  qvm_pkg::queue_ctl_t ctl,
  input  qvm_pkg::snap_t      wr_data,
  output qvm_pkg::queue_stat_t stat,
  output qvm_pkg::snap_t      rd_data
);

  qvm_pkg::snap_t                    mem [qvm_pkg::QueueDepth];
  logic [qvm_pkg::QueuePtrW-1:0]     wr_ptr;
  logic [qvm_pkg::QueuePtrW-1:0]     rd_ptr;
  logic [qvm_pkg::QueueCntW-1:0]     count;
  logic                              do_push;
  logic                              do_pop;

  assign stat.full  = (count == qvm_pkg::QueueCntW'(qvm_pkg::QueueDepth));
  assign stat.empty = (count == '0);
  assign do_push    = ctl.push && !stat.full;
  assign do_pop     = ctl.pop && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/qvm_front.sv]
`default_nettype none
module qvm_front (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                accept,
  input  wire                                pin_a,
  input  wire                                pin_b,
  input  wire                                tick,
  input  wire [qvm_pkg::IntervalW-1:0]       interval_ms,
  output logic                               push,
  output qvm_pkg::snap_t                     snap
);

  logic                                 prev_a;
  logic                                 prev_b;
  logic                                 dir_reverse;
  logic signed [qvm_pkg::WindowBits-1:0] window_count;
  logic signed [qvm_pkg::TotalBits-1:0]  total_count;
  logic [qvm_pkg::IntervalW-1:0]        ms_elapsed;

  logic                                 ch_a;
  logic                                 ch_b;
  logic                                 step;
  logic                                 dir_next;
  logic signed [qvm_pkg::WindowBits-1:0] window_next;
  logic signed [qvm_pkg::TotalBits-1:0]  total_next;
  logic [qvm_pkg::IntervalW-1:0]        ms_inc;
  logic                                 window_end;

  always_comb begin
    ch_a     = pin_a != prev_a;
    ch_b     = pin_b != prev_b;
    step     = ch_a ^ ch_b;
    dir_next = dir_reverse;
    if (ch_b) begin
      dir_next = (pin_a == pin_b);
    end else if (ch_a) begin
      dir_next = (pin_a != pin_b);
    end
    window_next = window_count;
    total_next  = total_count;
    if (step) begin
      if (dir_next) begin
        if (window_count > -qvm_pkg::WindowMax) begin
          window_next = window_count - 1'b1;
        end
        total_next = total_count - 1'b1;
      end else begin
        if (window_count < qvm_pkg::WindowMax) begin
          window_next = window_count + 1'b1;
        end
        total_next = total_count + 1'b1;
      end
    end
    ms_inc     = (ms_elapsed == qvm_pkg::ElapsedMax) ? ms_elapsed : ms_elapsed + 1'b1;
    window_end = tick && (ms_inc >= interval_ms);
  end

  // The edge in the closing sample still belongs to the finished window.
  assign push         = accept && window_end;
  assign snap.window  = window_next;
  assign snap.total   = total_next;
  assign snap.reverse = dir_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a       <= 1'b1;
      prev_b       <= 1'b1;
      dir_reverse  <= 1'b0;
      window_count <= '0;
      total_count  <= '0;
      ms_elapsed   <= '0;
    end else if (accept) begin
      prev_a      <= pin_a;
      prev_b      <= pin_b;
      dir_reverse <= dir_next;
      total_count <= total_next;
      if (window_end) begin
        window_count <= '0;
        ms_elapsed   <= '0;
      end else begin
        window_count <= window_next;
        if (tick) begin
          ms_elapsed <= ms_inc;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/qvm_back.sv]
`default_nettype none
module qvm_back (
  input  wire                                   clk,
  input  wire                                   rst,
  input  qvm_pkg::queue_stat_t                  q_stat,
  input  qvm_pkg::snap_t                        q_data,
  input  qvm_pkg::scales_t                      scales,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [qvm_pkg::RateW-1:0]      rpm_fixed,
  output logic signed [qvm_pkg::RateW-1:0]      speed_fixed,
  output logic signed [qvm_pkg::DistW-1:0]      distance_fixed,
  output logic signed [qvm_pkg::WindowBits-1:0] window_pulses,
  output logic signed [qvm_pkg::TotalBits-1:0]  total_pulses,
  output logic                                  reverse
);

  qvm_pkg::back_state_t state;
  qvm_pkg::back_state_t state_next;

  logic [qvm_pkg::WindowBits-2:0] mag_w;
  logic [qvm_pkg::TotalBits-1:0]  mag_t;
  logic                           total_neg;
  logic [qvm_pkg::TotalBits-1:0]  mul_a;
  logic [qvm_pkg::ScaleW-1:0]     mul_b;
  logic [qvm_pkg::DistW-1:0]      prod;
  logic [qvm_pkg::RateW-1:0]      prod_rate;
  logic [qvm_pkg::WindowBits-1:0] win_abs;
  logic [qvm_pkg::TotalBits-1:0]  tot_abs;

  always_comb begin
    state_next = state;
    case (state)
      qvm_pkg::BACK_IDLE:  if (!q_stat.empty) state_next = qvm_pkg::BACK_RPM;
      qvm_pkg::BACK_RPM:   state_next = qvm_pkg::BACK_SPEED;
      qvm_pkg::BACK_SPEED: state_next = qvm_pkg::BACK_DIST;
      qvm_pkg::BACK_DIST:  state_next = qvm_pkg::BACK_HOLD;
      qvm_pkg::BACK_HOLD:  if (out_ready) state_next = qvm_pkg::BACK_IDLE;
      default:             state_next = qvm_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == qvm_pkg::BACK_IDLE) && !q_stat.empty;
    out_valid = (state == qvm_pkg::BACK_HOLD);
  end

  // One shared multiplier, used once per product.
  always_comb begin
    case (state)
      qvm_pkg::BACK_SPEED: begin
        mul_a = qvm_pkg::TotalBits'(mag_w);
        mul_b = scales.speed;
      end
      qvm_pkg::BACK_DIST: begin
        mul_a = mag_t;
        mul_b = scales.distance;
      end
      default: begin
        mul_a = qvm_pkg::TotalBits'(mag_w);
        mul_b = scales.rpm;
      end
    endcase
    prod      = qvm_pkg::DistW'(mul_a) * qvm_pkg::DistW'(mul_b);
    prod_rate = prod[qvm_pkg::RateW-1:0];
    win_abs   = q_data.window[qvm_pkg::WindowBits-1] ? -q_data.window : q_data.window;
    tot_abs   = q_data.total[qvm_pkg::TotalBits-1] ? -q_data.total : q_data.total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qvm_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      qvm_pkg::BACK_IDLE: begin
        if (!q_stat.empty) begin
          mag_w         <= win_abs[qvm_pkg::WindowBits-2:0];
          mag_t         <= tot_abs;
          total_neg     <= q_data.total[qvm_pkg::TotalBits-1];
          window_pulses <= q_data.window;
          total_pulses  <= q_data.total;
          reverse       <= q_data.reverse;
        end
      end
      qvm_pkg::BACK_RPM:   rpm_fixed   <= reverse ? -prod_rate : prod_rate;
      qvm_pkg::BACK_SPEED: speed_fixed <= reverse ? -prod_rate : prod_rate;
      qvm_pkg::BACK_DIST:  distance_fixed <= total_neg ? -prod : prod;
      default: ;
    endcase
  end

endmodule
`default_nettype wire
